/* rtl/xcfp_pkg.sv */
// ----------------------------------------------------------------------------
// XOR checked frame parser package
// Shared constants and the result record passed from the parser core to the
// output stage.
// ----------------------------------------------------------------------------
package xcfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'hBB;
  localparam int unsigned PAYLOAD_LEN = 5;
  localparam int unsigned COUNT_W = 3;

  localparam logic [1:0] STATUS_NONE      = 2'd0;
  localparam logic [1:0] STATUS_DELIVERED = 2'd1;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
  localparam logic [1:0] STATUS_BAD_CHECK = 2'd3;

  typedef struct packed {
    logic                        packet_end_echo;
    logic [47:0]                 source_station;
    logic [PAYLOAD_LEN-1:0][7:0] payload;
    logic [7:0]                  frame_kind;
    logic [7:0]                  frame_serial;
    logic [1:0]                  frame_status;
  } result_t;

endpackage

/* rtl/xor_checked_frame_parser.sv */
// ----------------------------------------------------------------------------
// XOR checked frame parser
// Finds sync-headed ten byte frames in a byte stream and reports each one.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while input ready is high and returns
// exactly one result per byte. Each byte is parsed by a single compare, XOR and
// state update in the parser core, and the result is registered into a two-entry
// output buffer, so a byte is still accepted in the cycle a pending result waits
// on the master side; input ready drops only when both entries are full.
module xor_checked_frame_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [55:0]   s_axis_tdata,   // rx_byte [7:0], sender_address [55:8]
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // frame_serial [7:0], frame_kind [15:8],
                                        // payload_0..4 [55:16], source_station [103:56]
  output logic [1:0]    m_axis_tuser,   // frame_status [1:0]
  output logic          m_axis_tlast
);

  xcfp_pkg::result_t res;
  xcfp_pkg::result_t out_q, out_d;
  xcfp_pkg::result_t skid_q, skid_d;
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  logic              take_in;
  logic              out_free;

  assign s_axis_tready = !skid_valid_q;
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  xcfp_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take_in),
    .rx_byte_i        (s_axis_tdata[7:0]),
    .sender_address_i (s_axis_tdata[55:8]),
    .packet_end_i     (s_axis_tlast),
    .result_o         (res)
  );

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      out_valid_d  = skid_valid_q || take_in;
      out_d        = skid_valid_q ? skid_q : res;
      skid_valid_d = 1'b0;
    end else if (take_in) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.source_station, out_q.payload,
                          out_q.frame_kind, out_q.frame_serial};
  assign m_axis_tuser  = out_q.frame_status;
  assign m_axis_tlast  = out_q.packet_end_echo;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid entry holds a result while the output entry is empty.");

  a_station_only_delivered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.frame_status != xcfp_pkg::STATUS_DELIVERED))
      |-> (out_q.source_station == 48'd0))
    else $error("Sender address shown on a result that is not a delivery.");

  a_empty_result_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.frame_status == xcfp_pkg::STATUS_NONE))
      |-> ((out_q.frame_serial == 8'd0) && (out_q.frame_kind == 8'd0)
           && (out_q.payload == '0)))
    else $error("Frame fields are not cleared on a result without a frame.");

endmodule

/* rtl/xcfp_parser.sv */
// ----------------------------------------------------------------------------
// XOR checked frame parser core
// Holds the parse state and turns one received byte into one result record.
// State advances only when a byte transfer is taken.
// ----------------------------------------------------------------------------
module xcfp_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    take_i,
  input  logic [7:0]              rx_byte_i,
  input  logic [47:0]             sender_address_i,
  input  logic                    packet_end_i,
  output xcfp_pkg::result_t       result_o
);

  localparam logic [2:0] PH_HEAD1  = 3'd0;
  localparam logic [2:0] PH_HEAD2  = 3'd1;
  localparam logic [2:0] PH_SERIAL = 3'd2;
  localparam logic [2:0] PH_KIND   = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CHECK  = 3'd5;

  localparam logic [xcfp_pkg::COUNT_W-1:0] COUNT_FULL =
    xcfp_pkg::COUNT_W'(xcfp_pkg::PAYLOAD_LEN);

  logic [2:0]                        phase_q, phase_d;
  logic [7:0]                        check_q, check_d;
  logic [7:0]                        serial_q, serial_d;
  logic [7:0]                        kind_q, kind_d;
  logic [xcfp_pkg::COUNT_W-1:0]      count_q, count_d;
  logic [7:0]                        last_serial_q, last_serial_d;
  logic                              seen_q, seen_d;
  logic [xcfp_pkg::PAYLOAD_LEN-1:0][7:0] store_q;
  logic                              store_we;
  logic [7:0]                        check_x;
  logic                              is_first;
  logic                              show;
  logic [1:0]                        status;
  logic [47:0]                       station;

  assign is_first = (rx_byte_i == xcfp_pkg::SYNC_FIRST);
  assign check_x  = (phase_q != PH_CHECK) ? (check_q ^ rx_byte_i) : check_q;

  always_comb begin
    phase_d       = phase_q;
    check_d       = check_x;
    serial_d      = serial_q;
    kind_d        = kind_q;
    count_d       = count_q;
    last_serial_d = last_serial_q;
    seen_d        = seen_q;
    store_we      = 1'b0;
    show          = 1'b0;
    status        = xcfp_pkg::STATUS_NONE;
    station       = '0;
    unique case (phase_q)
      PH_HEAD2: begin
        if (rx_byte_i == xcfp_pkg::SYNC_SECOND) begin
          phase_d = PH_SERIAL;
        end else begin
          check_d = is_first ? xcfp_pkg::SYNC_FIRST : check_q;
          phase_d = is_first ? PH_HEAD2 : PH_HEAD1;
        end
      end
      PH_SERIAL: begin
        serial_d = rx_byte_i;
        phase_d  = PH_KIND;
      end
      PH_KIND: begin
        kind_d  = rx_byte_i;
        count_d = '0;
        phase_d = PH_DATA;
      end
      PH_DATA: begin
        if (count_q < COUNT_FULL) begin
          store_we = 1'b1;
          count_d  = count_q + 1'b1;
          if (count_d == COUNT_FULL) begin
            phase_d = PH_CHECK;
          end
        end else begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        show    = 1'b1;
        phase_d = PH_HEAD1;
        if (check_q == rx_byte_i) begin
          if (seen_q && (serial_q == last_serial_q)) begin
            status = xcfp_pkg::STATUS_DUPLICATE;
          end else begin
            status        = xcfp_pkg::STATUS_DELIVERED;
            last_serial_d = serial_q;
            seen_d        = 1'b1;
            station       = sender_address_i;
          end
        end else begin
          status  = xcfp_pkg::STATUS_BAD_CHECK;
          check_d = is_first ? xcfp_pkg::SYNC_FIRST : (check_q ^ rx_byte_i);
          phase_d = is_first ? PH_HEAD2 : PH_HEAD1;
        end
      end
      default: begin
        check_d = is_first ? xcfp_pkg::SYNC_FIRST : check_x;
        phase_d = is_first ? PH_HEAD2 : PH_HEAD1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HEAD1;
      check_q       <= '0;
      count_q       <= '0;
      last_serial_q <= '0;
      seen_q        <= 1'b0;
    end else if (take_i) begin
      phase_q       <= phase_d;
      check_q       <= check_d;
      count_q       <= count_d;
      last_serial_q <= last_serial_d;
      seen_q        <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      serial_q <= serial_d;
      kind_q   <= kind_d;
      for (int k = 0; k < xcfp_pkg::PAYLOAD_LEN; k++) begin
        if (store_we && (count_q == xcfp_pkg::COUNT_W'(k))) begin
          store_q[k] <= rx_byte_i;
        end
      end
    end
  end

  always_comb begin
    result_o.frame_status    = status;
    result_o.frame_serial    = show ? serial_q : 8'd0;
    result_o.frame_kind      = show ? kind_q : 8'd0;
    result_o.payload         = show ? store_q : '0;
    result_o.source_station  = station;
    result_o.packet_end_echo = packet_end_i;
  end

endmodule
